// ----- src/ghash_accumulator_defines.svh -----
// Assertion helpers for the GHASH accumulator.
`ifndef GHASH_ACCUMULATOR_DEFINES_SVH
`define GHASH_ACCUMULATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Condition in this cycle implies property in the next cycle.
`define GHASH_ASSERT_NEXT(label, clock, reset, cond, prop) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
    else $error("assertion failed");
// Condition implies property in the same cycle.
`define GHASH_ASSERT_SAME(label, clock, reset, cond, prop) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
    else $error("assertion failed");
`else
`define GHASH_ASSERT_NEXT(label, clock, reset, cond, prop)
`define GHASH_ASSERT_SAME(label, clock, reset, cond, prop)
`endif

`endif

// ----- src/ghash_pkg.sv -----
package ghash_pkg;

  localparam int BlockWidth = 128;
  localparam int HalfWidth  = 64;
  localparam int CountWidth = 61;

  localparam logic [1:0] OP_AAD     = 2'd0;
  localparam logic [1:0] OP_TEXT    = 2'd1;
  localparam logic [1:0] OP_FINISH  = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  localparam logic [4:0] FULL_BLOCK_BYTES = 5'd16;

  // Product in GF(2^128) with the bit order of GCM: bit 127 of the vector is the
  // coefficient of x^0. The operands are reversed into plain polynomial order,
  // multiplied carry-less, and reduced by x^128 + x^7 + x^2 + x + 1 in two folds.
  function automatic logic [127:0] gf128_mul(logic [127:0] x, logic [127:0] y);
    logic [127:0] a;
    logic [127:0] b;
    logic [254:0] p;
    logic [133:0] t;
    logic [5:0]   u;
    logic [12:0]  w;
    logic [127:0] r;
    logic [127:0] z;
    for (int i = 0; i < 128; i++) begin
      a[i] = x[127-i];
      b[i] = y[127-i];
    end
    p = '0;
    for (int i = 0; i < 128; i++) begin
      if (b[i]) begin
        p = p ^ ({127'b0, a} << i);
      end
    end
    t = {7'b0, p[254:128]} ^ ({7'b0, p[254:128]} << 1) ^
        ({7'b0, p[254:128]} << 2) ^ ({7'b0, p[254:128]} << 7);
    u = t[133:128];
    w = {7'b0, u} ^ ({7'b0, u} << 1) ^ ({7'b0, u} << 2) ^ ({7'b0, u} << 7);
    r = p[127:0] ^ t[127:0] ^ {115'b0, w};
    for (int i = 0; i < 128; i++) begin
      z[i] = r[127-i];
    end
    return z;
  endfunction

endpackage

// ----- src/ghash_accumulator.sv -----
// GHASH accumulator: one GF(2^128) multiply-accumulate per word.
// The tag for a word is on the output in the cycle after it is accepted.
// Throughput: one word per cycle unless the tag output stalls; the full multiply and
// reduction sit between the input handshake and the accumulator register, which
// also drives the tag. Reset (rst, synchronous): clears the accumulator, both
// byte counts, the hash key registers and the output valid.
`include "ghash_accumulator_defines.svh"

module ghash_accumulator
  import ghash_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // APB-style configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [HalfWidth-1:0]  pwdata,
  output logic [HalfWidth-1:0]  prdata,
  output logic                  pready,
  // Input channel
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic [1:0]            opcode,
  input  logic [HalfWidth-1:0]  block_high,
  input  logic [HalfWidth-1:0]  block_low,
  input  logic [4:0]            valid_bytes,
  // Output channel
  output logic                  tag_valid,
  input  logic                  tag_stall,
  output logic [HalfWidth-1:0]  tag_high,
  output logic [HalfWidth-1:0]  tag_low
);

  logic [HalfWidth-1:0]  key_high;
  logic [HalfWidth-1:0]  key_low;
  logic [BlockWidth-1:0] accumulator;
  logic [BlockWidth-1:0] accumulator_next;
  logic [CountWidth-1:0] aad_count;
  logic [CountWidth-1:0] aad_count_next;
  logic [CountWidth-1:0] text_count;
  logic [CountWidth-1:0] text_count_next;
  logic                  out_valid;

  logic                  accept;
  logic                  cfg_write;
  logic [4:0]            nv_sat;
  logic [7:0]            mask_shift;
  logic [BlockWidth-1:0] block_mask;
  logic [BlockWidth-1:0] mul_in;
  logic [BlockWidth-1:0] product;
  logic                  do_absorb;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = paddr[3] ? key_low : key_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_write) begin
      if (paddr[3]) begin
        key_low <= pwdata;
      end else begin
        key_high <= pwdata;
      end
    end
  end

  // The output register frees up in the same cycle its word is taken.
  assign item_stall = out_valid && tag_stall;
  assign accept     = item_valid && !item_stall;

  assign nv_sat     = (valid_bytes > FULL_BLOCK_BYTES) ? FULL_BLOCK_BYTES : valid_bytes;
  assign mask_shift = {nv_sat, 3'b000};
  assign block_mask = ~({BlockWidth{1'b1}} >> mask_shift);

  always_comb begin
    if (opcode == OP_FINISH) begin
      mul_in = accumulator ^ {aad_count, 3'b000, text_count, 3'b000};
    end else begin
      mul_in = accumulator ^ ({block_high, block_low} & block_mask);
    end
  end

  assign product = gf128_mul(mul_in, {key_high, key_low});

  always_comb begin
    accumulator_next = accumulator;
    aad_count_next   = aad_count;
    text_count_next  = text_count;
    do_absorb        = 1'b0;
    unique case (opcode)
      OP_RESTART: begin
        accumulator_next = '0;
        aad_count_next   = '0;
        text_count_next  = '0;
      end
      OP_FINISH: begin
        do_absorb = 1'b1;
      end
      OP_AAD: begin
        do_absorb      = (nv_sat != 5'd0);
        aad_count_next = do_absorb ? aad_count + CountWidth'(nv_sat) : aad_count;
      end
      OP_TEXT: begin
        do_absorb       = (nv_sat != 5'd0);
        text_count_next = do_absorb ? text_count + CountWidth'(nv_sat) : text_count;
      end
      default: begin
        do_absorb = 1'b0;
      end
    endcase
    if (do_absorb) begin
      accumulator_next = product;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      aad_count   <= '0;
      text_count  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        accumulator <= accumulator_next;
        aad_count   <= aad_count_next;
        text_count  <= text_count_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!tag_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign tag_valid = out_valid;
  assign tag_high  = accumulator[BlockWidth-1:HalfWidth];
  assign tag_low   = accumulator[HalfWidth-1:0];

  // A restart word leaves a zero tag behind it.
  `GHASH_ASSERT_NEXT(a_restart_clears, clk, rst, accept && opcode == OP_RESTART,
                     tag_valid && tag_high == '0 && tag_low == '0)
  // An absorb with no bytes kept returns the tag unchanged.
  `GHASH_ASSERT_NEXT(a_empty_absorb_holds, clk, rst,
                     accept && (opcode == OP_AAD || opcode == OP_TEXT) && valid_bytes == 5'd0,
                     tag_valid && tag_high == $past(tag_high) && tag_low == $past(tag_low))
  // Every accepted word produces a result word in the next cycle.
  `GHASH_ASSERT_NEXT(a_accept_gives_tag, clk, rst, accept, tag_valid)

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import ghash_pkg::*;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] bh;
    logic [63:0] bl;
    logic [4:0]  nv;
  } word_t;

  localparam logic [3:0] ADDR_KEY_HIGH = 4'd0;
  localparam logic [3:0] ADDR_KEY_LOW  = 4'd8;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [1:0]  opcode = OP_AAD;
  logic [63:0] block_high = '0;
  logic [63:0] block_low = '0;
  logic [4:0]  valid_bytes = '0;
  logic        tag_valid;
  logic        tag_stall = 1'b0;
  logic [63:0] tag_high;
  logic [63:0] tag_low;

  ghash_accumulator dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .item_valid(item_valid), .item_stall(item_stall), .opcode(opcode),
    .block_high(block_high), .block_low(block_low), .valid_bytes(valid_bytes),
    .tag_valid(tag_valid), .tag_stall(tag_stall),
    .tag_high(tag_high), .tag_low(tag_low)
  );

  // Shadow of the block: hash key, accumulator and the two byte counts.
  logic [127:0] hash_key = '0;
  logic [127:0] acc_state = '0;
  logic [60:0]  aad_bytes = '0;
  logic [60:0]  text_bytes = '0;

  word_t        pending[$];
  logic [127:0] tag_q[$];
  word_t        cur;
  int           words_sent = 0;
  int           tags_checked = 0;
  int           finishes = 0;
  int           restarts = 0;
  int           key_settings = 0;
  int           errors = 0;
  int           cycles = 0;
  int           hold_left = 0;
  bit           hold_done = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Multiply by H in GF(2^128), GCM bit order: bit 127 is the x^0 coefficient.
  function automatic logic [127:0] times_key(logic [127:0] v);
    logic [127:0] z;
    z = '0;
    for (int i = 0; i < 128; i++) begin
      if (hash_key[127-i]) z ^= v;
      v = v[0] ? ((v >> 1) ^ {8'he1, 120'b0}) : (v >> 1);
    end
    return z;
  endfunction

  function automatic logic [127:0] ghash_step(word_t w);
    logic [4:0]   keep;
    logic [127:0] mask;
    case (w.op)
      OP_RESTART: begin
        acc_state = '0;
        aad_bytes = '0;
        text_bytes = '0;
      end
      OP_FINISH: begin
        acc_state = times_key(acc_state ^ {aad_bytes, 3'b000, text_bytes, 3'b000});
      end
      default: begin
        keep = (w.nv > FULL_BLOCK_BYTES) ? FULL_BLOCK_BYTES : w.nv;
        if (keep != 0) begin
          mask = {128{1'b1}} << (8 * (16 - keep));
          acc_state = times_key(acc_state ^ ({w.bh, w.bl} & mask));
          if (w.op == OP_AAD) aad_bytes = aad_bytes + keep;
          else text_bytes = text_bytes + keep;
        end
      end
    endcase
    return acc_state;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void queue_word(logic [1:0] op, logic [63:0] bh, logic [63:0] bl,
                                     logic [4:0] nv);
    word_t w;
    w.op = op;
    w.bh = bh;
    w.bl = bl;
    w.nv = nv;
    pending.push_back(w);
  endfunction

  // A well-formed message: optional restart, full AAD and text blocks with a
  // possibly partial last block of each, then the length block.
  function automatic void queue_message(bit fresh);
    int n_aad;
    int n_text;
    n_aad = $urandom_range(3);
    n_text = $urandom_range(4);
    if (fresh) queue_word(OP_RESTART, rand64(), rand64(), 5'($urandom));
    for (int i = 0; i < n_aad; i++)
      queue_word(OP_AAD, rand64(), rand64(),
                 (i == n_aad - 1) ? 5'($urandom_range(1, 16)) : FULL_BLOCK_BYTES);
    for (int i = 0; i < n_text; i++)
      queue_word(OP_TEXT, rand64(), rand64(),
                 (i == n_text - 1) ? 5'($urandom_range(1, 16)) : FULL_BLOCK_BYTES);
    queue_word(OP_FINISH, rand64(), rand64(), 5'($urandom));
  endfunction

  function automatic void fill_random(int n);
    int start;
    start = pending.size();
    while (pending.size() - start < n) begin
      if ($urandom_range(9) == 0)
        queue_word(2'($urandom), rand64(), rand64(), 5'($urandom));
      else
        queue_message($urandom_range(3) != 0);
    end
  endfunction

  task automatic write_reg(logic [3:0] addr, logic [63:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_key(logic [63:0] hi, logic [63:0] lo);
    write_reg(ADDR_KEY_HIGH, hi);
    write_reg(ADDR_KEY_LOW, lo);
    hash_key = {hi, lo};
    key_settings++;
  endtask

  // The sender stays quiet until every tag has come back.
  task automatic drain();
    while (pending.size() != 0 || item_valid || tag_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    set_key(rand64(), rand64());
    queue_word(OP_RESTART, '0, '0, '0);
    queue_word(OP_AAD, '1, '1, FULL_BLOCK_BYTES);
    queue_word(OP_AAD, rand64(), rand64(), 5'd0);
    queue_word(OP_AAD, '1, '1, 5'd1);
    queue_word(OP_AAD, rand64(), rand64(), 5'd8);
    queue_word(OP_AAD, '1, '1, 5'd9);
    queue_word(OP_AAD, rand64(), rand64(), 5'd15);
    queue_word(OP_AAD, '1, '1, 5'd31);
    queue_word(OP_TEXT, '0, '0, FULL_BLOCK_BYTES);
    queue_word(OP_TEXT, '1, '1, 5'd7);
    queue_word(OP_TEXT, rand64(), rand64(), 5'd17);
    queue_word(OP_TEXT, '1, '1, 5'd0);
    queue_word(OP_FINISH, '1, '1, 5'd31);
    // Absorbing after a finish keeps extending the same hash.
    queue_word(OP_TEXT, rand64(), rand64(), FULL_BLOCK_BYTES);
    queue_word(OP_FINISH, '0, '0, '0);
    queue_word(OP_RESTART, '1, '1, 5'd31);
    queue_word(OP_FINISH, rand64(), rand64(), 5'd16);
    queue_word(OP_AAD, rand64(), rand64(), FULL_BLOCK_BYTES);
    queue_word(OP_TEXT, rand64(), rand64(), 5'd24);
    queue_word(OP_FINISH, '0, '0, '0);
    fill_random(95);
    drain();

    set_key('1, '1);
    fill_random(95);
    drain();

    // With this key the multiply is the identity.
    set_key(64'h8000_0000_0000_0000, '0);
    fill_random(95);
    drain();

    set_key('0, '0);
    fill_random(95);
    drain();

    repeat (10) @(posedge clk);
    $display("tb: %0d words sent (%0d finishes, %0d restarts), %0d tags checked",
             words_sent, finishes, restarts, tags_checked);
    $display("tb: %0d hash key settings, including all-zero, all-one and identity",
             key_settings);
    if (errors == 0 && tag_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Sender side.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        tag_q.push_back(ghash_step(cur));
        if (cur.op == OP_FINISH) finishes++;
        if (cur.op == OP_RESTART) restarts++;
        words_sent++;
      end
      if (!item_valid || !item_stall) begin
        if (pending.size() != 0 &&
            ((words_sent >= 200 && words_sent < 280) || $urandom_range(99) >= 24)) begin
          cur = pending.pop_front();
          opcode <= cur.op;
          block_high <= cur.bh;
          block_low <= cur.bl;
          valid_bytes <= cur.nv;
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver side: checks each tag and holds off once for a long stretch.
  always @(posedge clk) begin
    if (!rst) begin
      if (tag_valid && !tag_stall) begin
        if (tag_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("tb: unexpected tag %h_%h", tag_high, tag_low);
        end else begin
          logic [127:0] want;
          want = tag_q.pop_front();
          if (tag_high !== want[127:64]) begin
            errors++;
            if (errors <= 10)
              $display("tb: tag %0d tag_high expected %h got %h",
                       tags_checked, want[127:64], tag_high);
          end
          if (tag_low !== want[63:0]) begin
            errors++;
            if (errors <= 10)
              $display("tb: tag %0d tag_low expected %h got %h",
                       tags_checked, want[63:0], tag_low);
          end
        end
        tags_checked++;
      end
      if (!hold_done && tags_checked >= 60) begin
        hold_left = 300;
        hold_done = 1'b1;
      end
    end
    if (hold_left > 0) begin
      tag_stall <= 1'b1;
      hold_left--;
    end else if (tags_checked >= 200 && tags_checked < 280) begin
      tag_stall <= 1'b0;
    end else begin
      tag_stall <= ($urandom_range(99) < 24);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb: FAIL");
      $finish;
    end
  end

endmodule

// ----- sim.f -----
+incdir+src
src/ghash_pkg.sv
src/ghash_accumulator.sv
sim/tb.sv
